/* hdl/sph_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the spatial point hash
// no dependencies

package sph_pkg;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVX,
        S_DIVZ,
        S_HASH,
        S_PRB_WAIT,
        S_PRB_CHK,
        S_INS_CWAIT,
        S_INS_WR,
        S_RESULT,
        S_Q_R2,
        S_Q_NB,
        S_Q_CWAIT,
        S_Q_CELL,
        S_Q_PWAIT,
        S_Q_DIST,
        S_Q_SQX,
        S_Q_SQZ,
        S_Q_EMIT,
        S_Q_NEXT,
        S_Q_NBINC,
        S_Q_FIN
    } t_state;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_UNDEF  = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_HIT      = 3'd2;
    localparam logic [2:0] ST_NO_HIT   = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

endpackage

/* hdl/sph_cell_div.sv */
`timescale 1ns / 1ps
// floor division of a signed coordinate by the bucket size, by reciprocal multiply
// standalone, used by spatial_point_hash

module sph_cell_div #(
    parameter int BUCKET_SIZE = 2560
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic [31:0] o_coord
);

    // q = (a * m) >> SH is exact for every 32-bit unsigned a with this m
    localparam int SH = 32 + $clog2(BUCKET_SIZE);
    localparam int AW = SH + 32;
    localparam logic [63:0] RECIP    = (64'd1 << SH) / 64'(BUCKET_SIZE) + 64'd1;
    localparam logic [16:0] RECIP_LO = RECIP[16:0];
    localparam logic [15:0] RECIP_HI = RECIP[32:17];
    localparam logic [31:0] BIAS     = 32'(BUCKET_SIZE - 1);

    logic          r_busy;
    logic          r_step;
    logic          r_done;
    logic          r_neg;
    logic [31:0]   r_a;
    logic [AW-1:0] r_acc;

    logic [31:0]   mag;
    logic [48:0]   prod_lo;
    logic [47:0]   prod_hi;
    logic [31:0]   quot;

    always_comb begin
        mag     = i_value[31] ? 32'(-i_value) : i_value;
        prod_lo = 49'(r_a) * 49'(RECIP_LO);
        prod_hi = 48'(r_a) * 48'(RECIP_HI);
        quot    = r_acc[SH +: 32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 1'b0;
                r_neg  <= i_value[31];
                // floor of a negative is minus the ceiling of its magnitude
                r_a    <= i_value[31] ? mag + BIAS : mag;
            end else if (r_busy) begin
                if (!r_step) begin
                    r_acc  <= AW'(prod_lo);
                    r_step <= 1'b1;
                end else begin
                    r_acc  <= r_acc + (AW'(prod_hi) << 17);
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_coord = r_neg ? 32'(-quot) : quot;

endmodule

/* hdl/spatial_point_hash.sv */
`timescale 1ns / 1ps
// spatial point hash: grid cells, linear-probed cell map, per-cell point chains
// depends on sph_pkg and sph_cell_div

// One item at a time. Every insert and query first runs both coordinates
// through a reciprocal-multiply divider, then probes the cell map slot by
// slot. A query probes up to nine neighbour cells and walks their chains,
// so its length follows the data. After reset and after every clear the
// cell map is swept, one slot a cycle, before the next item is taken.
// POINT_SLOTS and MAP_SLOTS must be powers of two. Results wait in an output
// register and are held under backpressure.

module spatial_point_hash #(
    parameter int POINT_SLOTS = 2048,
    parameter int MAP_SLOTS   = 4096,
    parameter int BUCKET_SIZE = 2560,
    parameter int MAX_HITS    = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_z,
    input  logic [15:0]        i_river_id,
    input  logic [13:0]        i_point_width,
    input  logic [15:0]        i_radius,
    input  logic [6:0]         i_max_hits,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_hit_x,
    output logic signed [31:0] o_hit_z,
    output logic [15:0]        o_hit_river_id,
    output logic [13:0]        o_hit_width,
    output logic               o_last
);

    localparam int PW      = $clog2(POINT_SLOTS);
    localparam int MAP_W   = $clog2(MAP_SLOTS);
    localparam int MW      = (MAP_W > 16) ? MAP_W : 16;
    localparam int CW      = $clog2(MAX_HITS + 1);
    localparam int SLOT_DW = 1 + 64 + PW;
    localparam int PT_DW   = 32 + 32 + 16 + 14;
    localparam logic [PW:0]      PTS_FULL  = (PW + 1)'(POINT_SLOTS);
    localparam logic [MAP_W-1:0] SLOT_LAST = MAP_W'(MAP_SLOTS - 1);
    localparam logic [CW-1:0]    LIM_CAP   = CW'(MAX_HITS);
    localparam logic [MW-1:0]    HASH_LOW  = sph_pkg::HASH_MUL[MW-1:0];

    // memories
    logic [SLOT_DW-1:0] slot_mem [MAP_SLOTS];
    logic [PT_DW-1:0]   pt_mem   [POINT_SLOTS];
    logic [PW-1:0]      link_mem [POINT_SLOTS];
    logic [2*PW-1:0]    cell_mem [POINT_SLOTS];

    logic [SLOT_DW-1:0] r_slot_rd;
    logic [PT_DW-1:0]   r_pt_rd;
    logic [PW-1:0]      r_link_rd;
    logic [2*PW-1:0]    r_cell_rd;

    // control and working registers
    sph_pkg::t_state    r_state, n_state;
    logic               r_tell, n_tell;
    logic [1:0]         r_mode, n_mode;
    logic [31:0]        r_px, n_px, r_pz, n_pz;
    logic [15:0]        r_id, n_id;
    logic [13:0]        r_wd, n_wd;
    logic [15:0]        r_rad, n_rad;
    logic [CW-1:0]      r_lim, n_lim;
    logic [31:0]        r_cx, n_cx, r_cz, n_cz;
    logic [63:0]        r_key, n_key;
    logic [MAP_W-1:0]   r_slot, n_slot;
    logic [MAP_W-1:0]   r_probe, n_probe;
    logic [PW-1:0]      r_cell, n_cell;
    logic [PW-1:0]      r_p, n_p;
    logic [PW-1:0]      r_tail, n_tail;
    logic [PW:0]        r_np, n_np;
    logic [PW:0]        r_nc, n_nc;
    logic               r_found, n_found;
    logic [CW-1:0]      r_count, n_count;
    logic [1:0]         r_ox, n_ox, r_oz, n_oz;
    logic [31:0]        r_r2, n_r2;
    logic [31:0]        r_acc, n_acc;
    logic [15:0]        r_dx, n_dx, r_dz, n_dz;
    logic [2:0]         r_status, n_status;
    logic               r_hold_v, n_hold_v;
    logic [PT_DW-1:0]   r_hold, n_hold;

    // output register
    logic               r_ov;
    logic [2:0]         r_o_status;
    logic [PT_DW-1:0]   r_o_pt;
    logic               r_o_last;

    // comb helpers
    logic               slot_we, pt_we, link_we, cell_we;
    logic [SLOT_DW-1:0] slot_wdata;
    logic [2*PW-1:0]    cell_wdata;
    logic [MW-1:0]      mul_a, mul_b;
    logic [2*MW-1:0]    mul_p;
    logic               div_start, div_done;
    logic [31:0]        div_value, div_coord;
    logic               emit, e_hit, e_last;
    logic               out_free;
    logic               slot_occ, slot_hit, slot_last;
    logic [63:0]        slot_key;
    logic [PW-1:0]      slot_cidx;
    logic [PW-1:0]      head_rd, tail_rd;
    logic [31:0]        pt_x, pt_z;
    logic [32:0]        ddx, ddz, adx, adz;
    logic [32:0]        dist2;

    assign slot_occ  = r_slot_rd[SLOT_DW-1];
    assign slot_key  = r_slot_rd[SLOT_DW-2 -: 64];
    assign slot_cidx = r_slot_rd[PW-1:0];
    assign head_rd   = r_cell_rd[2*PW-1:PW];
    assign tail_rd   = r_cell_rd[PW-1:0];
    assign pt_x      = r_pt_rd[PT_DW-1 -: 32];
    assign pt_z      = r_pt_rd[PT_DW-33 -: 32];
    assign mul_p     = mul_a * mul_b;

    sph_cell_div #(
        .BUCKET_SIZE(BUCKET_SIZE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_value (div_value),
        .o_done  (div_done),
        .o_coord (div_coord)
    );

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[r_slot] <= slot_wdata;
        end
        r_slot_rd <= slot_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[r_np[PW-1:0]] <= {r_px, r_pz, r_id, r_wd};
        end
        r_pt_rd <= pt_mem[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[tail_rd] <= r_np[PW-1:0];
        end
        r_link_rd <= link_mem[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            cell_mem[r_cell] <= cell_wdata;
        end
        r_cell_rd <= cell_mem[r_cell];
    end

    always_comb begin
        n_state  = r_state;
        n_tell   = r_tell;
        n_mode   = r_mode;
        n_px     = r_px;
        n_pz     = r_pz;
        n_id     = r_id;
        n_wd     = r_wd;
        n_rad    = r_rad;
        n_lim    = r_lim;
        n_cx     = r_cx;
        n_cz     = r_cz;
        n_key    = r_key;
        n_slot   = r_slot;
        n_probe  = r_probe;
        n_cell   = r_cell;
        n_p      = r_p;
        n_tail   = r_tail;
        n_np     = r_np;
        n_nc     = r_nc;
        n_found  = r_found;
        n_count  = r_count;
        n_ox     = r_ox;
        n_oz     = r_oz;
        n_r2     = r_r2;
        n_acc    = r_acc;
        n_dx     = r_dx;
        n_dz     = r_dz;
        n_status = r_status;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;

        slot_we    = 1'b0;
        slot_wdata = '0;
        pt_we      = 1'b0;
        link_we    = 1'b0;
        cell_we    = 1'b0;
        cell_wdata = '0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_value  = r_pz;
        emit       = 1'b0;
        e_hit      = 1'b0;
        e_last     = 1'b1;
        o_in_ready = 1'b0;
        out_free   = !r_ov || i_out_ready;

        slot_hit  = slot_occ && (slot_key == r_key);
        slot_last = r_probe == SLOT_LAST;

        ddx   = {pt_x[31], pt_x} - {r_px[31], r_px};
        ddz   = {pt_z[31], pt_z} - {r_pz[31], r_pz};
        adx   = ddx[32] ? 33'(-ddx) : ddx;
        adz   = ddz[32] ? 33'(-ddz) : ddz;
        dist2 = 33'(r_acc) + 33'(mul_p[31:0]);

        case (r_state)
            sph_pkg::S_CLEAR: begin
                slot_we = 1'b1;
                if (r_slot == SLOT_LAST) begin
                    n_slot = '0;
                    n_tell = 1'b0;
                    if (r_tell) begin
                        n_status = sph_pkg::ST_CLEARED;
                        n_state  = sph_pkg::S_RESULT;
                    end else begin
                        n_state = sph_pkg::S_IDLE;
                    end
                end else begin
                    n_slot = r_slot + MAP_W'(1);
                end
            end
            sph_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode = i_mode;
                    n_px   = i_point_x;
                    n_pz   = i_point_z;
                    n_id   = i_river_id;
                    n_wd   = i_point_width;
                    n_rad  = i_radius;
                    n_lim  = (i_max_hits > 7'(MAX_HITS)) ? LIM_CAP : CW'(i_max_hits);
                    case (i_mode)
                        sph_pkg::MODE_CLEAR: begin
                            n_np    = '0;
                            n_nc    = '0;
                            n_tell  = 1'b1;
                            n_slot  = '0;
                            n_state = sph_pkg::S_CLEAR;
                        end
                        sph_pkg::MODE_INSERT, sph_pkg::MODE_QUERY: begin
                            div_start = 1'b1;
                            div_value = i_point_x;
                            n_state   = sph_pkg::S_DIVX;
                        end
                        default: begin
                            n_state = sph_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            sph_pkg::S_DIVX: begin
                if (div_done) begin
                    n_cx      = div_coord;
                    div_start = 1'b1;
                    div_value = r_pz;
                    n_state   = sph_pkg::S_DIVZ;
                end
            end
            sph_pkg::S_DIVZ: begin
                if (div_done) begin
                    n_cz = div_coord;
                    if (r_mode == sph_pkg::MODE_INSERT) begin
                        n_key   = {div_coord, r_cx};
                        n_state = sph_pkg::S_HASH;
                    end else begin
                        n_state = sph_pkg::S_Q_R2;
                    end
                end
            end
            sph_pkg::S_HASH: begin
                // only the low product bits matter for the home slot
                mul_a   = MW'(r_key[MAP_W-1:0]);
                mul_b   = HASH_LOW;
                n_slot  = mul_p[MAP_W-1:0];
                n_probe = '0;
                n_state = sph_pkg::S_PRB_WAIT;
            end
            sph_pkg::S_PRB_WAIT: begin
                n_state = sph_pkg::S_PRB_CHK;
            end
            sph_pkg::S_PRB_CHK: begin
                n_found = slot_hit;
                if (r_mode == sph_pkg::MODE_INSERT) begin
                    if (r_np >= PTS_FULL) begin
                        n_status = sph_pkg::ST_REJECTED;
                        n_state  = sph_pkg::S_RESULT;
                    end else if (slot_hit) begin
                        n_cell  = slot_cidx;
                        n_state = sph_pkg::S_INS_CWAIT;
                    end else if (!slot_occ) begin
                        if (r_nc >= PTS_FULL) begin
                            n_status = sph_pkg::ST_REJECTED;
                            n_state  = sph_pkg::S_RESULT;
                        end else begin
                            n_cell  = r_nc[PW-1:0];
                            n_state = sph_pkg::S_INS_WR;
                        end
                    end else if (slot_last) begin
                        n_status = sph_pkg::ST_REJECTED;
                        n_state  = sph_pkg::S_RESULT;
                    end else begin
                        n_slot  = r_slot + MAP_W'(1);
                        n_probe = r_probe + MAP_W'(1);
                        n_state = sph_pkg::S_PRB_WAIT;
                    end
                end else begin
                    if (slot_hit) begin
                        n_cell  = slot_cidx;
                        n_state = sph_pkg::S_Q_CWAIT;
                    end else if (!slot_occ || slot_last) begin
                        n_state = sph_pkg::S_Q_NBINC;
                    end else begin
                        n_slot  = r_slot + MAP_W'(1);
                        n_probe = r_probe + MAP_W'(1);
                        n_state = sph_pkg::S_PRB_WAIT;
                    end
                end
            end
            sph_pkg::S_INS_CWAIT: begin
                n_state = sph_pkg::S_INS_WR;
            end
            sph_pkg::S_INS_WR: begin
                pt_we   = 1'b1;
                cell_we = 1'b1;
                if (r_found) begin
                    link_we    = 1'b1;
                    cell_wdata = {head_rd, r_np[PW-1:0]};
                end else begin
                    slot_we    = 1'b1;
                    slot_wdata = {1'b1, r_key, r_cell};
                    cell_wdata = {r_np[PW-1:0], r_np[PW-1:0]};
                    n_nc       = r_nc + (PW + 1)'(1);
                end
                n_np     = r_np + (PW + 1)'(1);
                n_status = sph_pkg::ST_INSERTED;
                n_state  = sph_pkg::S_RESULT;
            end
            sph_pkg::S_RESULT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = sph_pkg::S_IDLE;
                end
            end
            sph_pkg::S_Q_R2: begin
                mul_a    = MW'(r_rad);
                mul_b    = MW'(r_rad);
                n_r2     = mul_p[31:0];
                n_ox     = '0;
                n_oz     = '0;
                n_count  = '0;
                n_hold_v = 1'b0;
                n_state  = sph_pkg::S_Q_NB;
            end
            sph_pkg::S_Q_NB: begin
                if (r_count >= r_lim) begin
                    n_state = sph_pkg::S_Q_FIN;
                end else begin
                    n_key   = {r_cz + 32'(r_oz) - 32'd1, r_cx + 32'(r_ox) - 32'd1};
                    n_state = sph_pkg::S_HASH;
                end
            end
            sph_pkg::S_Q_CWAIT: begin
                n_state = sph_pkg::S_Q_CELL;
            end
            sph_pkg::S_Q_CELL: begin
                n_p     = head_rd;
                n_tail  = tail_rd;
                n_state = sph_pkg::S_Q_PWAIT;
            end
            sph_pkg::S_Q_PWAIT: begin
                n_state = sph_pkg::S_Q_DIST;
            end
            sph_pkg::S_Q_DIST: begin
                n_dx = adx[15:0];
                n_dz = adz[15:0];
                if (adx <= 33'(r_rad) && adz <= 33'(r_rad)) begin
                    n_state = sph_pkg::S_Q_SQX;
                end else begin
                    n_state = sph_pkg::S_Q_NEXT;
                end
            end
            sph_pkg::S_Q_SQX: begin
                mul_a   = MW'(r_dx);
                mul_b   = MW'(r_dx);
                n_acc   = mul_p[31:0];
                n_state = sph_pkg::S_Q_SQZ;
            end
            sph_pkg::S_Q_SQZ: begin
                mul_a = MW'(r_dz);
                mul_b = MW'(r_dz);
                if (dist2 <= 33'(r_r2)) begin
                    n_state = sph_pkg::S_Q_EMIT;
                end else begin
                    n_state = sph_pkg::S_Q_NEXT;
                end
            end
            sph_pkg::S_Q_EMIT: begin
                // a hit is held back one step so the final one can carry last
                if (!r_hold_v) begin
                    n_hold   = r_pt_rd;
                    n_hold_v = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_state  = sph_pkg::S_Q_NEXT;
                end else if (out_free) begin
                    emit    = 1'b1;
                    e_hit   = 1'b1;
                    e_last  = 1'b0;
                    n_hold  = r_pt_rd;
                    n_count = r_count + CW'(1);
                    n_state = sph_pkg::S_Q_NEXT;
                end
            end
            sph_pkg::S_Q_NEXT: begin
                if (r_count >= r_lim || r_p == r_tail) begin
                    n_state = sph_pkg::S_Q_NBINC;
                end else begin
                    n_p     = r_link_rd;
                    n_state = sph_pkg::S_Q_PWAIT;
                end
            end
            sph_pkg::S_Q_NBINC: begin
                if (r_ox == 2'd2) begin
                    n_ox = '0;
                    if (r_oz == 2'd2) begin
                        n_state = sph_pkg::S_Q_FIN;
                    end else begin
                        n_oz    = r_oz + 2'd1;
                        n_state = sph_pkg::S_Q_NB;
                    end
                end else begin
                    n_ox    = r_ox + 2'd1;
                    n_state = sph_pkg::S_Q_NB;
                end
            end
            sph_pkg::S_Q_FIN: begin
                if (r_hold_v) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        e_hit    = 1'b1;
                        n_hold_v = 1'b0;
                        n_state  = sph_pkg::S_IDLE;
                    end
                end else begin
                    n_status = sph_pkg::ST_NO_HIT;
                    n_state  = sph_pkg::S_RESULT;
                end
            end
            default: begin
                n_state = sph_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sph_pkg::S_CLEAR;
            r_tell   <= 1'b0;
            r_slot   <= '0;
            r_np     <= '0;
            r_nc     <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tell   <= n_tell;
            r_slot   <= n_slot;
            r_np     <= n_np;
            r_nc     <= n_nc;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_px     <= n_px;
        r_pz     <= n_pz;
        r_id     <= n_id;
        r_wd     <= n_wd;
        r_rad    <= n_rad;
        r_lim    <= n_lim;
        r_cx     <= n_cx;
        r_cz     <= n_cz;
        r_key    <= n_key;
        r_probe  <= n_probe;
        r_cell   <= n_cell;
        r_p      <= n_p;
        r_tail   <= n_tail;
        r_found  <= n_found;
        r_count  <= n_count;
        r_ox     <= n_ox;
        r_oz     <= n_oz;
        r_r2     <= n_r2;
        r_acc    <= n_acc;
        r_dx     <= n_dx;
        r_dz     <= n_dz;
        r_status <= n_status;
        r_hold   <= n_hold;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_status <= e_hit ? sph_pkg::ST_HIT : r_status;
            r_o_pt     <= e_hit ? r_hold : '0;
            r_o_last   <= e_last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_o_status;
    assign o_hit_x        = r_o_pt[PT_DW-1 -: 32];
    assign o_hit_z        = r_o_pt[PT_DW-33 -: 32];
    assign o_hit_river_id = r_o_pt[29:14];
    assign o_hit_width    = r_o_pt[13:0];
    assign o_last         = r_o_last;

endmodule

/* tb/sv/tb_spatial_point_hash.sv */
`timescale 1ns / 1ps
// self-checking testbench for the spatial point hash: directed and random items
// depends on sph_pkg and the spatial_point_hash rtl

module tb_spatial_point_hash;

    localparam int POINT_CAP = 2048;
    localparam int MAP_CAP   = 4096;
    localparam int BUCKET    = 2560;
    localparam int HIT_CAP   = 64;

    typedef struct {
        logic [2:0]         status;
        logic signed [31:0] x;
        logic signed [31:0] z;
        logic [15:0]        owner;
        logic [13:0]        breadth;
        logic               last;
    } t_hit;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_mode = sph_pkg::MODE_CLEAR;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_z = '0;
    logic [15:0]        i_river_id = '0;
    logic [13:0]        i_point_width = '0;
    logic [15:0]        i_radius = '0;
    logic [6:0]         i_max_hits = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_status;
    logic signed [31:0] o_hit_x;
    logic signed [31:0] o_hit_z;
    logic [15:0]        o_hit_river_id;
    logic [13:0]        o_hit_width;
    logic               o_last;

    spatial_point_hash u_top (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] pt_x [POINT_CAP];
    logic signed [31:0] pt_z [POINT_CAP];
    logic [15:0]        pt_owner [POINT_CAP];
    logic [13:0]        pt_breadth [POINT_CAP];
    int                 pt_next [POINT_CAP];
    logic [63:0]        map_key [MAP_CAP];
    bit                 map_used [MAP_CAP];
    int                 map_cell [MAP_CAP];
    int                 chain_head [POINT_CAP];
    int                 chain_tail [POINT_CAP];
    int                 n_points = 0;
    int                 n_cells = 0;

    t_hit pending_hits[$];
    int   mismatches = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    bit   quiet = 1'b0;
    int   out_stall = 0;

    function automatic logic [31:0] grid_coord(logic signed [31:0] v);
        longint lv;
        longint q;
        lv = v;
        q = lv / BUCKET;
        if (lv < 0 && lv % BUCKET != 0) q--;
        return q[31:0];
    endfunction

    // probe for a cell key; free_slot is MAP_CAP when the map is full
    function automatic bit lookup_cell(logic [63:0] key, output int cidx, output int free_slot);
        logic [63:0] h;
        int s;
        h = key * sph_pkg::HASH_MUL;
        s = int'(h % 64'(MAP_CAP));
        free_slot = MAP_CAP;
        cidx = 0;
        for (int n = 0; n < MAP_CAP; n++) begin
            if (!map_used[s]) begin
                free_slot = s;
                return 1'b0;
            end
            if (map_key[s] == key) begin
                cidx = map_cell[s];
                return 1'b1;
            end
            s = (s + 1) % MAP_CAP;
        end
        return 1'b0;
    endfunction

    function automatic void push_status(logic [2:0] st);
        t_hit h;
        h = '{st, 0, 0, 0, 0, 1'b1};
        pending_hits.push_back(h);
    endfunction

    function automatic void predict_item(logic [1:0] mode, logic signed [31:0] px,
                                         logic signed [31:0] pz, logic [15:0] id,
                                         logic [13:0] wd, logic [15:0] rad,
                                         logic [6:0] mh);
        logic [31:0] cx, cz;
        logic [63:0] key;
        int cidx, free_slot, p, lim, count, first;
        bit found;
        longint dx, dz, r;
        t_hit h;
        cx = grid_coord(px);
        cz = grid_coord(pz);
        case (mode)
            sph_pkg::MODE_CLEAR: begin
                foreach (map_used[i]) map_used[i] = 1'b0;
                n_points = 0;
                n_cells = 0;
                push_status(sph_pkg::ST_CLEARED);
            end
            sph_pkg::MODE_INSERT: begin
                key = {cz, cx};
                if (n_points >= POINT_CAP) begin
                    push_status(sph_pkg::ST_REJECTED);
                    return;
                end
                found = lookup_cell(key, cidx, free_slot);
                if (!found && (free_slot >= MAP_CAP || n_cells >= POINT_CAP)) begin
                    push_status(sph_pkg::ST_REJECTED);
                    return;
                end
                p = n_points;
                pt_x[p] = px;
                pt_z[p] = pz;
                pt_owner[p] = id;
                pt_breadth[p] = wd;
                pt_next[p] = 0;
                if (found) begin
                    pt_next[chain_tail[cidx]] = p;
                    chain_tail[cidx] = p;
                end else begin
                    cidx = n_cells;
                    map_key[free_slot] = key;
                    map_cell[free_slot] = cidx;
                    map_used[free_slot] = 1'b1;
                    chain_head[cidx] = p;
                    chain_tail[cidx] = p;
                    n_cells++;
                end
                n_points++;
                push_status(sph_pkg::ST_INSERTED);
            end
            sph_pkg::MODE_QUERY: begin
                lim = (mh > HIT_CAP) ? HIT_CAP : mh;
                r = rad;
                count = 0;
                first = pending_hits.size();
                // 3x3 neighbourhood, z rows outer, x inner
                for (int oz = -1; oz <= 1; oz++) begin
                    for (int ox = -1; ox <= 1; ox++) begin
                        key = {cz + 32'(oz), cx + 32'(ox)};
                        if (!lookup_cell(key, cidx, free_slot)) continue;
                        p = chain_head[cidx];
                        for (int n = 0; n < n_points && count < lim; n++) begin
                            dx = longint'(pt_x[p]) - longint'(px);
                            dz = longint'(pt_z[p]) - longint'(pz);
                            if (dx < 0) dx = -dx;
                            if (dz < 0) dz = -dz;
                            if (dx <= r && dz <= r && dx * dx + dz * dz <= r * r) begin
                                h = '{sph_pkg::ST_HIT, pt_x[p], pt_z[p], pt_owner[p],
                                      pt_breadth[p], 1'b0};
                                pending_hits.push_back(h);
                                count++;
                            end
                            if (p == chain_tail[cidx]) break;
                            p = pt_next[p];
                        end
                    end
                end
                if (count == 0) push_status(sph_pkg::ST_NO_HIT);
                else pending_hits[first + count - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic int draw_wait();
        if (quiet) return 0;
        return $urandom_range(0, 14);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_item(logic [1:0] mode, logic signed [31:0] px,
                             logic signed [31:0] pz, logic [15:0] id = 0,
                             logic [13:0] wd = 0, logic [15:0] rad = 0,
                             logic [6:0] mh = 0);
        int gap;
        gap = draw_wait();
        repeat (gap) @(posedge i_clk);
        @(posedge i_clk);
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_point_x     <= px;
        i_point_z     <= pz;
        i_river_id    <= id;
        i_point_width <= wd;
        i_radius      <= rad;
        i_max_hits    <= mh;
        predict_item(mode, px, pz, id, wd, rad, mh);
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 1'b0;
        items_sent++;
    endtask

    task automatic wait_drain();
        while (pending_hits.size() != 0) @(posedge i_clk);
    endtask

    // output stalls drawn per result
    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            i_out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (o_out_valid && i_out_ready) out_stall <= draw_wait();
        end
    end

    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, -1);
            end else begin
                want = pending_hits.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_hit_x !== want.x) report_mismatch("hit_x", o_hit_x, want.x);
                if (o_hit_z !== want.z) report_mismatch("hit_z", o_hit_z, want.z);
                if (o_hit_river_id !== want.owner)
                    report_mismatch("hit_river_id", o_hit_river_id, want.owner);
                if (o_hit_width !== want.breadth)
                    report_mismatch("hit_width", o_hit_width, want.breadth);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
    end

    function automatic logic signed [31:0] near_coord();
        return $signed($urandom_range(0, 20480)) - 32'sd10240;
    endfunction

    task automatic test_empty_store();
        send_item(sph_pkg::MODE_QUERY, 0, 0, 0, 0, 16'hFFFF, 64);
        send_item(sph_pkg::MODE_CLEAR, 0, 0);
        send_item(sph_pkg::MODE_UNDEF, 0, 0);
    endtask

    task automatic test_directed();
        send_item(sph_pkg::MODE_INSERT, 0, 0, 16'h0000, 14'd0);
        send_item(sph_pkg::MODE_INSERT, -1, -1, 16'hFFFF, 14'd10240);
        send_item(sph_pkg::MODE_INSERT, 2559, 0, 16'hA5A5, 14'd8191);
        send_item(sph_pkg::MODE_INSERT, 2560, -2560, 16'h5A5A, 14'd5000);
        send_item(sph_pkg::MODE_INSERT, 32'sh7FFFFFFF, 32'sh80000000, 16'h1234, 14'd1);
        send_item(sph_pkg::MODE_INSERT, 32'sh80000000, 32'sh7FFFFFFF, 16'h4321, 14'd9999);
        send_item(sph_pkg::MODE_INSERT, 0, 0, 16'h00FF, 14'd77);
        send_item(sph_pkg::MODE_QUERY, 0, 0, 0, 0, 16'd0, 64);      // exact zero radius
        send_item(sph_pkg::MODE_QUERY, 0, 0, 0, 0, 16'hFFFF, 7'd127); // cap above limit
        send_item(sph_pkg::MODE_QUERY, 0, 0, 0, 0, 16'hFFFF, 7'd0);   // zero hits allowed
        send_item(sph_pkg::MODE_QUERY, 0, 0, 0, 0, 16'hFFFF, 7'd2);
        send_item(sph_pkg::MODE_QUERY, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 16'd1, 1);
        send_item(sph_pkg::MODE_QUERY, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 16'hFFFF, 64);
        send_item(sph_pkg::MODE_QUERY, 1280, -1280, 0, 0, 16'd2000, 64);
        send_item(sph_pkg::MODE_UNDEF, 32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF, 14'd10240,
                  16'hFFFF, 7'd127);
        send_item(sph_pkg::MODE_CLEAR, -1, -1);
        send_item(sph_pkg::MODE_QUERY, 0, 0, 0, 0, 16'hFFFF, 64);
        // hold off until all results are back
        wait_drain();
    endtask

    task automatic test_random();
        int pick;
        for (int i = 0; i < 430; i++) begin
            if (i % 60 == 30) quiet = 1'b1;
            if (i % 60 == 45) quiet = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_item(sph_pkg::MODE_INSERT, near_coord(), near_coord(), 16'($urandom),
                          14'($urandom_range(0, 10240)));
            else if (pick < 85)
                send_item(sph_pkg::MODE_QUERY, near_coord(), near_coord(), 0, 0,
                          16'(($urandom_range(0, 3) == 0) ? $urandom
                                                          : $urandom_range(0, 6000)),
                          7'($urandom_range(0, 127)));
            else if (pick < 91)
                send_item(sph_pkg::MODE_INSERT, $urandom, $urandom, 16'($urandom),
                          14'($urandom_range(0, 10240)));
            else if (pick < 95)
                send_item(sph_pkg::MODE_QUERY, $urandom, $urandom, 16'($urandom),
                          14'($urandom), 16'($urandom), 7'($urandom));
            else if (pick < 97)
                send_item(sph_pkg::MODE_CLEAR, $urandom, $urandom);
            else
                send_item(sph_pkg::MODE_UNDEF, $urandom, $urandom, 16'($urandom),
                          14'($urandom), 16'($urandom), 7'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_store();
        test_directed();
        test_random();
        wait_drain();
        repeat (300) @(posedge i_clk);
        $display("ran %0d items (empty store, corner coordinates, random mix with clears)",
                 items_sent);
        $display("checked %0d results with %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && pending_hits.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("timeout with %0d results outstanding", pending_hits.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
